// ----- design/swdm_pkg.sv -----
// Shared types and constants for the stack with delete-max block.
// No dependencies; imported by every module of the block.
`default_nettype none

package swdm_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int MAX_RESULTS     = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_DELMAX = 2'd2,
    OP_VIEW   = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [5:0]         position;
    logic signed [31:0] entry_value;
    logic [5:0]         depth_now;
    logic               last;
  } out_item_t;

  // Decoded command as it sits in the queue
  typedef struct packed {
    op_e_t              op;
    logic signed [31:0] value;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

`default_nettype wire

// ----- design/swdm_front.sv -----
// Front end: takes items, decodes the action and holds them in a two-entry queue.
// Depends on swdm_pkg.
`default_nettype none

module swdm_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  swdm_pkg::in_item_t  in_item,
  input  wire                 pop,
  output swdm_pkg::q_head_t   head
);
  import swdm_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push_q, pop_q;
  cmd_t       dec_cmd;

  assign busy   = (fill_r == 2'd2);
  assign push_q = start && !busy;
  assign pop_q  = pop && (fill_r != 2'd0);

  always_comb begin
    dec_cmd.op    = op_e_t'(in_item.action);
    dec_cmd.value = in_item.value;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_q;
    rd_ptr_nxt = rd_ptr_r ^ pop_q;
    fill_nxt   = fill_r + {1'b0, push_q} - {1'b0, pop_q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_mem_r[wr_ptr_r] <= dec_cmd;
    end
  end

  always_comb begin
    head.valid = (fill_r != 2'd0);
    head.cmd   = q_mem_r[rd_ptr_r];
  end

endmodule

`default_nettype wire

// ----- design/swdm_back.sv -----
// Back end: entry memory, count and the sequencer for push, clear,
// delete-max (scan then compaction) and view. Depends on swdm_pkg.
`default_nettype none

module swdm_back #(
  parameter int STACK_DEPTH = swdm_pkg::STACK_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  swdm_pkg::q_head_t    head,
  output logic                 pop,
  output logic                 out_strobe,
  output swdm_pkg::out_item_t  out_item
);
  import swdm_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int VW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_COMPACT = 4'b0100,
    S_VIEW    = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      iss_r, iss_nxt;
  logic [CW-1:0]      rcv_r, rcv_nxt;
  logic [CW-1:0]      wptr_r, wptr_nxt;
  logic signed [31:0] max_r, max_nxt;
  logic               rd_vld_r;
  logic signed [31:0] rd_data_r;
  logic               out_strobe_r, out_strobe_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic signed [31:0] store_mem [STACK_DEPTH];
  logic               rd_en;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  logic [VW-1:0]      view_n;
  logic [CW-1:0]      view_addr;
  logic               rcv_last;
  logic               view_last;
  logic               keep;

  always_comb begin
    view_n    = (VW'(cnt_r) < VW'(MAX_RESULTS)) ? VW'(cnt_r) : VW'(MAX_RESULTS);
    view_addr = cnt_r - CW'(1) - iss_r;
    rcv_last  = (rcv_r == (cnt_r - CW'(1)));
    view_last = ((VW'(rcv_r) + VW'(1)) == view_n);
    keep      = (rd_data_r != max_r);
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    iss_nxt        = iss_r;
    rcv_nxt        = rcv_r;
    wptr_nxt       = wptr_r;
    max_nxt        = max_r;
    rd_en          = 1'b0;
    raddr          = '0;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;
    pop            = 1'b0;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    out_item_nxt.status = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop     = 1'b1;
          iss_nxt = '0;
          rcv_nxt = '0;
          unique case (head.cmd.op)
            OP_PUSH: begin
              out_strobe_nxt    = 1'b1;
              out_item_nxt.last = 1'b1;
              if (cnt_r >= CW'(STACK_DEPTH)) begin
                out_item_nxt.status    = ST_FULL;
                out_item_nxt.depth_now = 6'(cnt_r);
              end else begin
                we                     = 1'b1;
                waddr                  = cnt_r[AW-1:0];
                wdata                  = head.cmd.value;
                cnt_nxt                = cnt_r + CW'(1);
                out_item_nxt.depth_now = 6'(cnt_nxt);
              end
            end
            OP_CLEAR: begin
              cnt_nxt           = '0;
              out_strobe_nxt    = 1'b1;
              out_item_nxt.last = 1'b1;
            end
            OP_DELMAX, OP_VIEW: begin
              if (cnt_r == '0) begin
                out_strobe_nxt      = 1'b1;
                out_item_nxt.status = ST_EMPTY;
                out_item_nxt.last   = 1'b1;
              end else if (head.cmd.op == OP_DELMAX) begin
                state_nxt = S_SCAN;
              end else begin
                state_nxt = S_VIEW;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (iss_r < cnt_r) begin
          rd_en   = 1'b1;
          raddr   = iss_r[AW-1:0];
          iss_nxt = iss_r + CW'(1);
        end
        if (rd_vld_r) begin
          if ((rcv_r == '0) || (rd_data_r > max_r)) begin
            max_nxt = rd_data_r;
          end
          rcv_nxt = rcv_r + CW'(1);
          if (rcv_last) begin
            state_nxt = S_COMPACT;
            iss_nxt   = '0;
            rcv_nxt   = '0;
            wptr_nxt  = '0;
          end
        end
      end

      S_COMPACT: begin
        // Writes land at wptr <= the index being read back, so reads ahead stay intact
        if (iss_r < cnt_r) begin
          rd_en   = 1'b1;
          raddr   = iss_r[AW-1:0];
          iss_nxt = iss_r + CW'(1);
        end
        if (rd_vld_r) begin
          rcv_nxt = rcv_r + CW'(1);
          if (keep) begin
            we       = 1'b1;
            waddr    = wptr_r[AW-1:0];
            wdata    = rd_data_r;
            wptr_nxt = wptr_r + CW'(1);
          end
          if (rcv_last) begin
            state_nxt                = S_IDLE;
            cnt_nxt                  = wptr_nxt;
            out_strobe_nxt           = 1'b1;
            out_item_nxt.entry_value = max_r;
            out_item_nxt.depth_now   = 6'(wptr_nxt);
            out_item_nxt.last        = 1'b1;
          end
        end
      end

      S_VIEW: begin
        if (VW'(iss_r) < view_n) begin
          rd_en   = 1'b1;
          raddr   = view_addr[AW-1:0];
          iss_nxt = iss_r + CW'(1);
        end
        if (rd_vld_r) begin
          rcv_nxt                  = rcv_r + CW'(1);
          out_strobe_nxt           = 1'b1;
          out_item_nxt.position    = 6'(rcv_nxt);
          out_item_nxt.entry_value = rd_data_r;
          out_item_nxt.depth_now   = 6'(cnt_r);
          out_item_nxt.last        = view_last;
          if (view_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      iss_r        <= '0;
      rcv_r        <= '0;
      wptr_r       <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      iss_r        <= iss_nxt;
      rcv_r        <= rcv_nxt;
      wptr_r       <= wptr_nxt;
      rd_vld_r     <= rd_en;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    max_r      <= max_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    rd_data_r <= store_mem[raddr];
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

// ----- design/stack_with_delete_max.sv -----
// Top level of the bounded stack with delete-max.
// Depends on swdm_pkg, swdm_front and swdm_back.
//
// Usage:
//   Input channel: an item (in_item.action, in_item.value) is taken at a
//   rising edge with start high and busy low. busy rises only when the
//   two-entry command queue is full, so items may be sent while the back
//   end is still working on an earlier one.
//   Result channel: out_strobe marks each result for one cycle; out_item
//   carries status, position, entry_value, depth_now and last. The
//   receiver cannot stall, so results are never held back.
// Results and back-end work (N = entries held):
//   push, clear, and any action on an empty stack: one result; the back
//   end handles such an item in its idle state.
//   delete-max: one result, after a scan pass and a compaction pass of
//   the back end, each one read of the entry memory per cycle.
//   view: min(N,32) results on consecutive cycles.
//   These passes and the view reads share the single read port of the
//   entry memory.
// Reset: synchronous, active low; the stack and queue come up empty.
`default_nettype none

module stack_with_delete_max #(
  parameter int STACK_DEPTH = swdm_pkg::STACK_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  swdm_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output swdm_pkg::out_item_t  out_item
);
  import swdm_pkg::*;

  q_head_t head;
  logic    pop;

  swdm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .pop     (pop),
    .head    (head)
  );

  swdm_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ----- design/swdm_checker.sv -----
// Port-level checker for stack_with_delete_max, bound to the top level.
// Depends on swdm_pkg.
`default_nettype none

module swdm_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_strobe,
  input swdm_pkg::out_item_t  out_item
);
  import swdm_pkg::*;

  // A view burst has no gaps until its last item
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> out_strobe)
    else $error("view burst broken before last");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.status == ST_EMPTY) |->
      (out_item.depth_now == 6'd0) && out_item.last && (out_item.position == 6'd0))
    else $error("empty result malformed");

  a_position_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.position != 6'd0) |-> (out_item.status == ST_OK))
    else $error("view entry with non-ok status");

  a_burst_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> (out_item.position == $past(out_item.position) + 6'd1))
    else $error("view positions out of order");

endmodule

bind stack_with_delete_max swdm_checker u_swdm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

`default_nettype wire

// ----- verif/tb_stack_with_delete_max.sv -----
// Self-checking testbench for stack_with_delete_max: directed table, then random bursts.
// Depends on swdm_pkg and the stack_with_delete_max RTL; predicts every result in-house.
`timescale 1ns / 100ps

module tb_stack_with_delete_max;
  import swdm_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int RAND_ITEMS   = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 40;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} burst_mode_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  // predictor state
  logic signed [31:0] stack_mem [DEPTH];
  int                 stack_cnt;
  out_item_t          expected_results [$];
  dir_row_t           dir_rows [$];

  int errors;
  int cycles;
  int results_seen;
  int op_counts [4];
  int full_drops;
  int multi_removals;
  int peak_depth;

  stack_with_delete_max #(.STACK_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  task automatic predict_stack_results(in_item_t it);
    out_item_t          r;
    logic signed [31:0] mx;
    int                 wr;
    int                 n;
    r.status      = ST_OK;
    r.position    = 6'd0;
    r.entry_value = 32'sd0;
    r.last        = 1'b1;
    op_counts[it.action]++;
    case (op_e_t'(it.action))
      OP_PUSH: begin
        if (stack_cnt >= DEPTH) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          stack_mem[stack_cnt] = it.value;
          stack_cnt++;
          if (stack_cnt > peak_depth) peak_depth = stack_cnt;
        end
      end
      OP_CLEAR: stack_cnt = 0;
      OP_DELMAX: begin
        if (stack_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          mx = stack_mem[0];
          for (int i = 1; i < stack_cnt; i++)
            if (stack_mem[i] > mx) mx = stack_mem[i];
          wr = 0;
          for (int i = 0; i < stack_cnt; i++)
            if (stack_mem[i] != mx) begin
              stack_mem[wr] = stack_mem[i];
              wr++;
            end
          if (stack_cnt - wr > 1) multi_removals++;
          stack_cnt     = wr;
          r.entry_value = mx;
        end
      end
      default: begin
        if (stack_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          n = (stack_cnt < MAX_RESULTS) ? stack_cnt : MAX_RESULTS;
          r.depth_now = 6'(stack_cnt);
          for (int i = 0; i < n; i++) begin
            r.position    = 6'(i + 1);
            r.entry_value = stack_mem[stack_cnt - 1 - i];
            r.last        = (i + 1 == n);
            expected_results.push_back(r);
          end
          return;
        end
      end
    endcase
    r.depth_now = 6'(stack_cnt);
    expected_results.push_back(r);
  endtask

  // Called just after a rising edge; returns just after the accepting edge
  // (or after the idle gap that follows it).
  task automatic send_item(in_item_t it, int gap, bit typed, out_item_t want);
    in_item_t junk;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_stack_results(it);
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
    if (gap > 0) begin
      junk.action = 2'($urandom);
      junk.value  = $urandom;
      start   <= 1'b0;
      in_item <= junk;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Always lets at least one edge pass, so start is never assigned twice
  // in one time step.
  task automatic wait_drained(int tail);
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic add_row(op_e_t op, logic [31:0] val, bit typed,
                         status_t st, logic [31:0] ev, int dn);
    dir_row_t row;
    row.item.action      = op;
    row.item.value       = val;
    row.typed            = typed;
    row.want.status      = st;
    row.want.position    = 6'd0;
    row.want.entry_value = ev;
    row.want.depth_now   = 6'(dn);
    row.want.last        = 1'b1;
    dir_rows.push_back(row);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 7)) - 4;  // dense pool, many repeats
      7:          return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      8:          return $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
      default:    return $urandom | 32'h80000000;
    endcase
  endfunction

  function automatic op_e_t pick_action(burst_mode_t mode);
    int p;
    p = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  return p < 85 ? OP_PUSH : (p < 95 ? OP_VIEW : OP_DELMAX);
      MODE_DRAIN: return p < 60 ? OP_DELMAX : (p < 85 ? OP_VIEW : OP_PUSH);
      default: begin
        if (p < 45) return OP_PUSH;
        if (p < 70) return OP_DELMAX;
        if (p < 93) return OP_VIEW;
        return OP_CLEAR;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_item));
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                          results_seen, out_item.status, want.status));
        if (out_item.position !== want.position)
          report_mismatch($sformatf("result %0d position %0d, want %0d",
                          results_seen, out_item.position, want.position));
        if (out_item.entry_value !== want.entry_value)
          report_mismatch($sformatf("result %0d entry_value %0d, want %0d",
                          results_seen, out_item.entry_value, want.entry_value));
        if (out_item.depth_now !== want.depth_now)
          report_mismatch($sformatf("result %0d depth_now %0d, want %0d",
                          results_seen, out_item.depth_now, want.depth_now));
        if (out_item.last !== want.last)
          report_mismatch($sformatf("result %0d last %0b, want %0b",
                          results_seen, out_item.last, want.last));
      end
    end
  end

  initial begin
    in_item_t    it;
    out_item_t   none;
    burst_mode_t mode;
    int          rand_sent;
    int          burst;
    int          burst_len;
    bit          no_idle;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    none      = '0;
    stack_cnt = 0;

    add_row(OP_VIEW,   32'h0,        1, ST_EMPTY, 32'h0,        0);
    add_row(OP_DELMAX, 32'h12345678, 1, ST_EMPTY, 32'h0,        0);
    add_row(OP_CLEAR,  32'hffffffff, 1, ST_OK,    32'h0,        0);
    add_row(OP_PUSH,   32'h7fffffff, 1, ST_OK,    32'h0,        1);
    add_row(OP_PUSH,   32'h80000000, 1, ST_OK,    32'h0,        2);
    add_row(OP_PUSH,   32'hffffffff, 1, ST_OK,    32'h0,        3);
    add_row(OP_PUSH,   32'h7fffffff, 1, ST_OK,    32'h0,        4);
    add_row(OP_PUSH,   32'h0,        1, ST_OK,    32'h0,        5);
    add_row(OP_VIEW,   32'h0,        0, ST_OK,    32'h0,        0);
    add_row(OP_DELMAX, 32'h0,        1, ST_OK,    32'h7fffffff, 3);
    add_row(OP_VIEW,   32'hffffffff, 0, ST_OK,    32'h0,        0);
    add_row(OP_DELMAX, 32'h0,        1, ST_OK,    32'h0,        2);
    add_row(OP_DELMAX, 32'h0,        1, ST_OK,    32'hffffffff, 1);
    add_row(OP_VIEW,   32'h0,        0, ST_OK,    32'h0,        0);
    add_row(OP_DELMAX, 32'h0,        1, ST_OK,    32'h80000000, 0);
    add_row(OP_DELMAX, 32'h0,        1, ST_EMPTY, 32'h0,        0);
    add_row(OP_PUSH,   32'h5,        1, ST_OK,    32'h0,        1);
    add_row(OP_PUSH,   32'h5,        1, ST_OK,    32'h0,        2);
    add_row(OP_PUSH,   32'h5,        1, ST_OK,    32'h0,        3);
    add_row(OP_PUSH,   32'hfffffffd, 1, ST_OK,    32'h0,        4);
    // all three copies of the maximum go at once
    add_row(OP_DELMAX, 32'h0,        1, ST_OK,    32'h5,        1);
    add_row(OP_VIEW,   32'h0,        0, ST_OK,    32'h0,        0);
    add_row(OP_PUSH,   32'h1,        1, ST_OK,    32'h0,        2);
    add_row(OP_CLEAR,  32'h0,        1, ST_OK,    32'h0,        0);
    add_row(OP_VIEW,   32'h0,        1, ST_EMPTY, 32'h0,        0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, $urandom_range(0, 6), dir_rows[i].typed, dir_rows[i].want);

    rand_sent = 0;
    burst     = 0;
    while (rand_sent < RAND_ITEMS) begin
      // first burst is always a long fill burst, meant to reach the full-stack drop
      if (burst == 0) begin
        mode      = MODE_FILL;
        burst_len = 45;
      end else begin
        mode      = burst_mode_t'($urandom_range(0, 2));
        burst_len = $urandom_range(10, 40);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len && rand_sent < RAND_ITEMS; k++) begin
        it.action = pick_action(mode);
        it.value  = pick_value();
        send_item(it, no_idle ? 0 : $urandom_range(0, 6), 1'b0, none);
        rand_sent++;
      end
      if (burst == 0 || $urandom_range(0, 2) == 0)
        wait_drained($urandom_range(0, 6));
      burst++;
    end

    wait_drained(80);

    $display("Sent %0d items: %0d push, %0d clear, %0d delete-max, %0d view; %0d results checked.",
             dir_rows.size() + rand_sent, op_counts[OP_PUSH], op_counts[OP_CLEAR],
             op_counts[OP_DELMAX], op_counts[OP_VIEW], results_seen);
    $display("Peak depth %0d, %0d pushes dropped when full, %0d delete-max with duplicates.",
             peak_depth, full_drops, multi_removals);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
